// ===== src/e2c_pkg.sv =====
// Package for the epoch-seconds to calendar converter.
// Holds the shared constants, the month table and the day divider result type.
// No dependencies.
`default_nettype none

package e2c_pkg;

  localparam int unsigned TotalW = 33;
  localparam int unsigned DsecW  = 17;

  localparam logic [TotalW-1:0] SecsTo1970  = 33'd2208988800;
  localparam logic [DsecW-1:0]  SecsPerDay  = 17'd86400;
  localparam logic [DsecW-1:0]  SecsPerHour = 17'd3600;
  localparam logic [11:0]       SecsPerMin  = 12'd60;
  localparam logic [8:0]        DaysPerYear = 9'd365;
  localparam logic [2:0]        WdayOf1900  = 3'd1;

  typedef struct packed {
    logic             done;
    logic [DsecW-1:0] dsec;
    logic [2:0]       wday;
    logic [7:0]       yr_est;
    logic [8:0]       r365;
  } day_res_t;

  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && (mon >= 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/e2c_if.sv =====
// Handshake interfaces for the input beat and the result beat.
// No dependencies.
`default_nettype none

interface e2c_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] seconds_in;
  logic               dst_in;

  modport source (output valid, output seconds_in, output dst_in, input ready);
  modport sink   (input valid, input seconds_in, input dst_in, output ready);
endinterface

interface e2c_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [5:0] second_out;
  logic [5:0] minute_out;
  logic [4:0] hour_out;
  logic [4:0] month_day;
  logic [3:0] month_index;
  logic [7:0] year_since_1900;
  logic [2:0] week_day;
  logic [8:0] year_day;
  logic       dst_out;

  modport source (output valid, output valid_res, output second_out, output minute_out,
                  output hour_out, output month_day, output month_index,
                  output year_since_1900, output week_day, output year_day,
                  output dst_out, input ready);
  modport sink   (input valid, input valid_res, input second_out, input minute_out,
                  input hour_out, input month_day, input month_index,
                  input year_since_1900, input week_day, input year_day,
                  input dst_out, output ready);
endinterface

`default_nettype wire

// ===== src/e2c_day_div.sv =====
// Bit-serial division of the 1900-based second count by the length of a day.
// Quotient bits are folded on the fly into the weekday and a days/365 estimate.
// Depends on e2c_pkg.
`default_nettype none

module e2c_day_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [e2c_pkg::TotalW-1:0]    total_i,
  output e2c_pkg::day_res_t             res_o
);
  import e2c_pkg::*;

  logic [TotalW-1:0] num_q, num_d;
  logic [DsecW-1:0]  rem_q, rem_d;
  logic [2:0]        m7_q, m7_d;
  logic [8:0]        r365_q, r365_d;
  logic [7:0]        yq_q, yq_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [DsecW:0] trial;
  logic           qbit;
  logic [3:0]     m7_t;
  logic [9:0]     r365_t;
  logic           yge;

  always_comb begin
    trial  = {rem_q, num_q[TotalW-1]};
    qbit   = (trial >= {1'b0, SecsPerDay});
    m7_t   = {m7_q, qbit};
    r365_t = {r365_q, qbit};
    yge    = (r365_t >= {1'b0, DaysPerYear});

    num_d  = num_q;
    rem_d  = rem_q;
    m7_d   = m7_q;
    r365_d = r365_q;
    yq_d   = yq_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (start_i) begin
      num_d  = total_i;
      rem_d  = '0;
      m7_d   = '0;
      r365_d = '0;
      yq_d   = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d  = {num_q[TotalW-2:0], 1'b0};
      rem_d  = qbit ? DsecW'(trial - {1'b0, SecsPerDay}) : trial[DsecW-1:0];
      m7_d   = (m7_t >= 4'd7) ? 3'(m7_t - 4'd7) : m7_t[2:0];
      r365_d = yge ? 9'(r365_t - {1'b0, DaysPerYear}) : r365_t[8:0];
      yq_d   = {yq_q[6:0], yge};
      cnt_d  = cnt_q + 6'd1;
      if (cnt_q == 6'(TotalW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    m7_q   <= m7_d;
    r365_q <= r365_d;
    yq_q   <= yq_d;
  end

  logic [3:0] wday_t;

  always_comb begin
    wday_t       = {1'b0, m7_q} + {1'b0, WdayOf1900};
    res_o.done   = done_q;
    res_o.dsec   = rem_q;
    res_o.wday   = (wday_t >= 4'd7) ? 3'(wday_t - 4'd7) : wday_t[2:0];
    res_o.yr_est = yq_q;
    res_o.r365   = r365_q;
  end

  property p_done_after_busy;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q && $past(busy_q);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without a run");

  property p_start_runs;
    @(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q && (cnt_q == 6'd0);
  endproperty
  a_start_runs: assert property (p_start_runs) else $error("division did not start");

  property p_rem_bound;
    @(posedge clk_i) disable iff (!rst_ni) busy_q |-> (rem_q < SecsPerDay) && (r365_q < DaysPerYear);
  endproperty
  a_rem_bound: assert property (p_rem_bound) else $error("partial remainder out of range");

endmodule

`default_nettype wire

// ===== src/epoch_seconds_to_calendar_top.sv =====
// Top level of the epoch-seconds to calendar converter.
// One item at a time: a new input beat is taken only once the last item has been loaded into
// the result register, after the 33-step serial day division and the 5-step hour and 6-step
// minute divisions; a stalled result holds the next item back.
// Reset: asynchronous and active low; the block comes up idle with no result pending.
// Depends on e2c_pkg, e2c_if and e2c_day_div.
`default_nettype none

module epoch_seconds_to_calendar_top (
  input logic        clk_i,
  input logic        rst_ni,
  e2c_in_if.sink     in_i,
  e2c_out_if.source  out_o
);
  import e2c_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DAY  = 5'b00010,
    S_HOUR = 5'b00100,
    S_MIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic              err_q, err_d;
  logic              dst_q, dst_d;
  logic [TotalW-1:0] total;
  logic              start;
  day_res_t          day_res;

  logic [DsecW-1:0] hrem_q, hrem_d;
  logic [4:0]       hour_q, hour_d;
  logic [5:0]       min_q, min_d;
  logic [2:0]       k_q, k_d;
  logic [2:0]       wday_q, wday_d;
  logic [7:0]       year_q, year_d;
  logic [8:0]       yday_q, yday_d;

  logic [DsecW-1:0] hdiv;
  logic [DsecW-1:0] mdiv;

  logic [7:0] yfix;
  logic [9:0] rfix;
  logic [7:0] lp0, lp1;
  logic       ydec;

  logic       leap;
  logic [3:0] mon;
  logic [8:0] mbase;
  logic [4:0] mday;

  logic out_valid_q, out_valid_d;
  logic load_out;

  assign in_i.ready = (state_q == S_IDLE);
  assign start      = in_i.valid && in_i.ready;
  assign total      = TotalW'({2'b00, SecsTo1970} + {{3{in_i.seconds_in[31]}}, in_i.seconds_in}
                      + (in_i.dst_in ? 35'({1'b0, SecsPerHour}) : 35'd0));

  e2c_day_div u_day_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .total_i (total),
    .res_o   (day_res)
  );

  always_comb begin
    lp0  = (day_res.yr_est != 8'd0) ? ((day_res.yr_est - 8'd1) >> 2) : 8'd0;
    ydec = (day_res.yr_est != 8'd0) && ({1'b0, day_res.r365} < {2'b00, lp0});
    yfix = ydec ? (day_res.yr_est - 8'd1) : day_res.yr_est;
    rfix = ydec ? ({1'b0, day_res.r365} + {1'b0, DaysPerYear}) : {1'b0, day_res.r365};
    lp1  = (yfix != 8'd0) ? ((yfix - 8'd1) >> 2) : 8'd0;
  end

  always_comb begin
    hdiv = SecsPerHour << k_q;
    mdiv = {5'd0, SecsPerMin} << k_q;
  end

  always_comb begin
    leap = (year_q[1:0] == 2'b00) && (year_q != 8'd0);
    mon  = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (yday_q >= cum_days(leap, 4'(m))) begin
        mon = 4'(m);
      end
    end
    mbase = cum_days(leap, mon);
    mday  = 5'(yday_q - mbase + 9'd1);
  end

  assign load_out = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    dst_d   = dst_q;
    hrem_d  = hrem_q;
    hour_d  = hour_q;
    min_d   = min_q;
    k_d     = k_q;
    wday_d  = wday_q;
    year_d  = year_q;
    yday_d  = yday_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          err_d   = &in_i.seconds_in;
          dst_d   = in_i.dst_in;
          state_d = S_DAY;
        end
      end
      S_DAY: begin
        if (day_res.done) begin
          hrem_d  = day_res.dsec;
          wday_d  = day_res.wday;
          year_d  = yfix;
          yday_d  = 9'(rfix - {2'b00, lp1});
          hour_d  = '0;
          min_d   = '0;
          k_d     = 3'd4;
          state_d = S_HOUR;
        end
      end
      S_HOUR: begin
        if (hrem_q >= hdiv) begin
          hrem_d = hrem_q - hdiv;
          hour_d = {hour_q[3:0], 1'b1};
        end else begin
          hour_d = {hour_q[3:0], 1'b0};
        end
        if (k_q == 3'd0) begin
          k_d     = 3'd5;
          state_d = S_MIN;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      S_MIN: begin
        if (hrem_q >= mdiv) begin
          hrem_d = hrem_q - mdiv;
          min_d  = {min_q[4:0], 1'b1};
        end else begin
          min_d  = {min_q[4:0], 1'b0};
        end
        if (k_q == 3'd0) begin
          state_d = S_OUT;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    dst_q  <= dst_d;
    hrem_q <= hrem_d;
    hour_q <= hour_d;
    min_q  <= min_d;
    wday_q <= wday_d;
    year_q <= year_d;
    yday_q <= yday_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_o.valid_res       <= !err_q;
      out_o.second_out      <= err_q ? 6'd0 : hrem_q[5:0];
      out_o.minute_out      <= err_q ? 6'd0 : min_q;
      out_o.hour_out        <= err_q ? 5'd0 : hour_q;
      out_o.month_day       <= err_q ? 5'd0 : mday;
      out_o.month_index     <= err_q ? 4'd0 : mon;
      out_o.year_since_1900 <= err_q ? 8'd0 : year_q;
      out_o.week_day        <= err_q ? 3'd0 : wday_q;
      out_o.year_day        <= err_q ? 9'd0 : yday_q;
      out_o.dst_out         <= err_q ? 1'b0 : dst_q;
    end
  end

  assign out_o.valid = out_valid_q;

  property p_state_onehot;
    @(posedge clk_i) disable iff (!rst_ni) $onehot(state_q);
  endproperty
  a_state_onehot: assert property (p_state_onehot) else $error("state register corrupt");

  property p_accept_starts;
    @(posedge clk_i) disable iff (!rst_ni) start |=> (state_q == S_DAY);
  endproperty
  a_accept_starts: assert property (p_accept_starts) else $error("accepted beat not started");

  property p_done_in_day;
    @(posedge clk_i) disable iff (!rst_ni) day_res.done |-> (state_q == S_DAY);
  endproperty
  a_done_in_day: assert property (p_done_in_day) else $error("day division out of step");

  property p_load_sets_valid;
    @(posedge clk_i) disable iff (!rst_ni) load_out |=> out_valid_q && (state_q == S_IDLE);
  endproperty
  a_load_sets_valid: assert property (p_load_sets_valid) else $error("result beat lost");

  property p_fields_in_range;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && out_o.valid_res |-> (out_o.hour_out < 5'd24) && (out_o.minute_out < 6'd60)
        && (out_o.second_out < 6'd60) && (out_o.month_index < 4'd12) && (out_o.week_day < 3'd7);
  endproperty
  a_fields_in_range: assert property (p_fields_in_range) else $error("result field out of range");

endmodule

`default_nettype wire

// ===== sim/epoch_calendar_checker.sv =====
`timescale 1ns / 100ps
// Checker for the epoch-seconds to calendar converter: it watches the input and result channels,
// predicts every calendar date and compares each result beat field by field, in order.
// Depends on e2c_if; it hands its failure count and the number of awaited results to the bench.

module epoch_calendar_checker (
  input  logic clk_i,
  input  logic rst_ni,
  e2c_in_if    in_i,
  e2c_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam longint OffsetTo1900 = 64'd2208988800;
  localparam longint DaySecs      = 86400;
  localparam longint HourSecs     = 3600;
  localparam longint MinSecs      = 60;
  localparam int     PrintLimit   = 100;

  typedef struct packed {
    logic       valid_res;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] month;
    logic [7:0] year;
    logic [2:0] wday;
    logic [8:0] yday;
    logic       dst;
  } calendar_t;

  calendar_t expected_dates[$];
  calendar_t got_date;
  calendar_t want_date;
  int        result_idx;

  function automatic longint days_before_year(input longint yr);
    return (yr == 0) ? 0 : 365 * yr + (yr - 1) / 4;
  endfunction

  function automatic longint month_length(input logic leap, input longint mon);
    case (mon)
      1:          return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic calendar_t epoch_to_calendar(input logic signed [31:0] secs,
                                                  input logic dst);
    calendar_t date;
    longint    s;
    longint    days;
    longint    day_secs;
    longint    yr;
    longint    yd;
    longint    mon;
    longint    left;
    logic      leap;
    date = '0;
    if (secs == -1) return date;
    s = secs;
    days = 0;
    if (s <= 0) begin
      day_secs = OffsetTo1900 + s;
    end else begin
      days = s / DaySecs;
      day_secs = OffsetTo1900 + s % DaySecs;
    end
    if (dst) day_secs = day_secs + HourSecs;
    days = days + day_secs / DaySecs;
    day_secs = day_secs % DaySecs;
    yr = days / 365;
    while (yr > 0 && days < days_before_year(yr)) yr--;
    yd = days - days_before_year(yr);
    leap = (yr % 4 == 0) && (yr != 0);
    mon = 0;
    left = yd;
    while (left >= month_length(leap, mon)) begin
      left = left - month_length(leap, mon);
      mon++;
    end
    date.valid_res = 1'b1;
    date.second    = 6'(day_secs % MinSecs);
    date.minute    = 6'((day_secs % HourSecs) / MinSecs);
    date.hour      = 5'(day_secs / HourSecs);
    date.mday      = 5'(left + 1);
    date.month     = 4'(mon);
    date.year      = 8'(yr);
    date.wday      = 3'((days + 1) % 7);
    date.yday      = 9'(yd);
    date.dst       = dst;
    return date;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count_o < PrintLimit) $display("%t mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %0d want %0d", result_idx, name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      expected_dates.delete();
      fail_count_o = 0;
      result_idx = 0;
      pending_o <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        got_date = {out_i.valid_res, out_i.second_out, out_i.minute_out, out_i.hour_out,
                    out_i.month_day, out_i.month_index, out_i.year_since_1900,
                    out_i.week_day, out_i.year_day, out_i.dst_out};
        if (expected_dates.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing awaited", result_idx));
        end else begin
          want_date = expected_dates.pop_front();
          check_field("valid_res", got_date.valid_res, want_date.valid_res);
          check_field("second_out", got_date.second, want_date.second);
          check_field("minute_out", got_date.minute, want_date.minute);
          check_field("hour_out", got_date.hour, want_date.hour);
          check_field("month_day", got_date.mday, want_date.mday);
          check_field("month_index", got_date.month, want_date.month);
          check_field("year_since_1900", got_date.year, want_date.year);
          check_field("week_day", got_date.wday, want_date.wday);
          check_field("year_day", got_date.yday, want_date.yday);
          check_field("dst_out", got_date.dst, want_date.dst);
        end
        result_idx++;
      end
      if (in_i.valid && in_i.ready) begin
        expected_dates.push_back(epoch_to_calendar(in_i.seconds_in, in_i.dst_in));
      end
      pending_o <= expected_dates.size();
    end
  end

endmodule

// ===== sim/epoch_seconds_to_calendar_top_tb.sv =====
`timescale 1ns / 100ps
// Bench top for the epoch-seconds to calendar converter: clock, reset, input beats in bursts,
// a stalling result receiver, a watchdog and the verdict. Depends on e2c_if, the block and
// epoch_calendar_checker, which does all prediction and comparison.

module epoch_seconds_to_calendar_top_tb;

  localparam int RandomBeats   = 1930;
  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles  = 60;

  logic clk;
  logic rst_n;
  int   fail_total;
  int   results_pending;
  int   burst_left;
  int   quiet_cycles;

  e2c_in_if  in_bus ();
  e2c_out_if out_bus ();

  epoch_seconds_to_calendar_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  epoch_calendar_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_bus),
    .out_i        (out_bus),
    .fail_count_o (fail_total),
    .pending_o    (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_beat(input logic signed [31:0] secs, input logic dst);
    in_bus.valid      <= 1'b1;
    in_bus.seconds_in <= secs;
    in_bus.dst_in     <= dst;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
    end
  endtask

  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    burst_left = $urandom_range(1, 6);
  endtask

  initial begin
    logic ready_now;
    int   span;
    out_bus.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      ready_now = ($urandom_range(0, 3) != 0);
      if (ready_now && $urandom_range(0, 7) == 0) span = $urandom_range(100, 400);
      else span = $urandom_range(1, 25);
      out_bus.ready <= ready_now;
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] secs;
    longint             stamp;
    longint             offs;
    int                 kind;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.seconds_in = '0;
    in_bus.dst_in     = 1'b0;
    burst_left        = 3;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(0, 1'b0);
    send_beat(0, 1'b1);
    send_beat(-1, 1'b0);
    send_beat(-1, 1'b1);
    send_beat(1, 1'b0);
    send_beat(-2, 1'b1);
    send_beat(32'sh7FFFFFFF, 1'b0);
    send_beat(32'sh7FFFFFFF, 1'b1);
    send_beat(32'sh80000000, 1'b0);
    send_beat(32'sh80000000, 1'b1);
    send_beat(86399, 1'b0);
    send_beat(86400, 1'b1);
    send_beat(-86400, 1'b0);
    send_beat(-86401, 1'b1);
    send_beat(-3600, 1'b1);
    send_beat(951782400, 1'b0);
    send_beat(951868799, 1'b1);
    send_beat(946684799, 1'b0);
    send_beat(978307199, 1'b1);
    send_beat(1230767999, 1'b0);
    send_beat(68255999, 1'b0);
    send_beat(-2147483647, 1'b0);
    send_beat(32'sh55555555, 1'b1);
    send_beat(32'shAAAAAAAA, 1'b0);
    wait_for_results();

    for (int i = 0; i < RandomBeats; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        secs = $urandom;
      end else if (kind < 80) begin
        case ($urandom_range(0, 7))
          0: offs = 0;
          1: offs = 1;
          2: offs = -1;
          3: offs = 86399;
          4: offs = 3599;
          5: offs = 82800;
          6: offs = 43200;
          default: offs = $urandom_range(0, 86399);
        endcase
        stamp = longint'(int'($urandom_range(0, 49710)) - 24855) * 86400 + offs;
        secs = stamp[31:0];
      end else if (kind < 88) begin
        secs = -1;
      end else if (kind < 95) begin
        secs = int'($urandom_range(0, 200000)) - 100000;
      end else if ($urandom_range(0, 1) == 1) begin
        secs = 32'sh7FFFFFFF - int'($urandom_range(0, 100000));
      end else begin
        secs = 32'sh80000000 + int'($urandom_range(0, 100000));
      end
      send_beat(secs, 1'($urandom_range(0, 1)));
      if (i == RandomBeats / 2) wait_for_results();
    end

    wait_for_results();
    repeat (SettleCycles) @(posedge clk);
    if (fail_total == 0 && results_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
